// ----- hw/rtl/can_node_heartbeat_monitor_macros.svh -----
// Assertion macros for the heartbeat monitor.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef CAN_NODE_HEARTBEAT_MONITOR_MACROS_SVH
`define CAN_NODE_HEARTBEAT_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define HBM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication
`define HBM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define HBM_ASSERT_NOW(lbl, pre, post)
`define HBM_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// ----- hw/rtl/hbm_pkg.sv -----
package hbm_pkg;

  // Field widths
  localparam int unsigned ReqW    = 3;
  localparam int unsigned FrameIdW = 11;
  localparam int unsigned NodeIdxW = 3;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 11;

  // Number of heartbeat identifier registers
  localparam int unsigned MaxNodes = 6;
  localparam int unsigned NodeCountDef = 6;

  // Reset values of the limit and countdown registers, also the table reset values
  localparam logic [CountW-1:0] FackLimitRst = 8'd3;
  localparam logic [CountW-1:0] InitStartRst = 8'd5;
  localparam logic [CountW-1:0] CountMax     = 8'hFF;

  typedef enum logic [ReqW-1:0] {
    REQ_FRAME  = 3'd0,
    REQ_FACK   = 3'd1,
    REQ_REPORT = 3'd2,
    REQ_STEP   = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_QUERY  = 3'd5
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE0_ID    = 3'd0,
    CFG_NODE1_ID    = 3'd1,
    CFG_NODE2_ID    = 3'd2,
    CFG_NODE3_ID    = 3'd3,
    CFG_NODE4_ID    = 3'd4,
    CFG_NODE5_ID    = 3'd5,
    CFG_FACK_LIMIT  = 3'd6,
    CFG_INIT_START  = 3'd7
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    ST_INIT = 2'd0,
    ST_CONN = 2'd1,
    ST_DISC = 2'd2
  } status_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [TickW-1:0]  last_heard;
    logic [CountW-1:0] fack;
    logic [CountW-1:0] report;
    logic [CountW-1:0] init;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Identifier lookup result
  typedef struct packed {
    logic                hit;
    logic [NodeIdxW-1:0] idx;
  } match_t;

  function automatic status_e status_of(logic [CountW-1:0] fack, logic [CountW-1:0] init,
                                        logic [CountW-1:0] limit);
    status_e st;
    if (init != '0) begin
      st = ST_INIT;
    end else if (fack < limit) begin
      st = ST_CONN;
    end else begin
      st = ST_DISC;
    end
    return st;
  endfunction

  function automatic status_e combine(status_e s1, status_e s0);
    status_e st;
    if (s1 == ST_INIT || s0 == ST_INIT) begin
      st = ST_INIT;
    end else if (s1 == ST_DISC || s0 == ST_DISC) begin
      st = ST_DISC;
    end else begin
      st = ST_CONN;
    end
    return st;
  endfunction

endpackage

// ----- hw/rtl/hbm_if.sv -----
// Event item channel
interface hbm_in_if;
  import hbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [FrameIdW-1:0] frame_id;
  logic [NodeIdxW-1:0] node_index;
  logic [TickW-1:0]    now_tick;

  modport source (output valid, req_type, frame_id, node_index, now_tick, input ready);
  modport sink   (input valid, req_type, frame_id, node_index, now_tick, output ready);
endinterface

// Result item channel
interface hbm_out_if;
  import hbm_pkg::*;
  logic               valid;
  logic               ready;
  logic               matched;
  logic [StatusW-1:0] node_status;
  logic [StatusW-1:0] combined_status;
  logic [TickW-1:0]   last_heard;
  logic [CountW-1:0]  fack_count;
  logic [CountW-1:0]  report_count;
  logic [CountW-1:0]  init_count;

  modport source (output valid, matched, node_status, combined_status, last_heard,
                  fack_count, report_count, init_count, input ready);
  modport sink   (input valid, matched, node_status, combined_status, last_heard,
                  fack_count, report_count, init_count, output ready);
endinterface

// Configuration write channel
interface hbm_cfg_if;
  import hbm_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/hbm_ram.sv -----
module hbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/hbm_regs.sv -----
module hbm_regs #(
  parameter int unsigned NODE_COUNT = hbm_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hbm_cfg_if.sink                       cfg_i,
  input  logic [hbm_pkg::FrameIdW-1:0]  frame_id_i,
  output hbm_pkg::match_t               match_o,
  output logic [hbm_pkg::CountW-1:0]    fack_limit_o
);
  import hbm_pkg::*;

  logic [FrameIdW-1:0] ids_q [MaxNodes];
  logic [CountW-1:0]   limit_q;

  assign cfg_i.ready = 1'b1;

  // Register writes; a countdown start write is accepted but changes nothing,
  // since the table reset value is fixed, so it has no visible effect
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNodes; i++) begin
        ids_q[i] <= '0;
      end
      limit_q <= FackLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NODE0_ID, CFG_NODE1_ID, CFG_NODE2_ID,
        CFG_NODE3_ID, CFG_NODE4_ID, CFG_NODE5_ID: begin
          ids_q[cfg_i.index] <= cfg_i.data;
        end
        CFG_FACK_LIMIT: begin
          limit_q <= cfg_i.data[CountW-1:0];
        end
        CFG_INIT_START: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Identifier lookup, lowest entry wins; identifier zero always hits entry 0
  always_comb begin
    match_o = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (ids_q[i] == frame_id_i) begin
        match_o.hit = 1'b1;
        match_o.idx = NodeIdxW'(i);
      end
    end
    if (frame_id_i == '0) begin
      match_o.hit = 1'b1;
      match_o.idx = '0;
    end
  end

  assign fack_limit_o = limit_q;

endmodule

// ----- hw/rtl/can_node_heartbeat_monitor.sv -----
// Channel  Dir  Handshake          Payload
// in_i     in   valid/ready        req_type, frame_id, node_index, now_tick
// out_o    out  valid/ready        matched, node_status, combined_status, entry fields
// cfg_i    in   valid/ready (=1)   index, data
//
// Each item's entry is read from the table RAM when the item is accepted and
// written back in S_RMW once the output register is free, so one item is in
// work at a time.
// The output register holds a finished result while the next item is accepted.
// Reset leaves the RAM contents alone; per-entry valid bits make unwritten
// entries read as their reset values, so no clearing pass is needed.
module can_node_heartbeat_monitor #(
  parameter int unsigned NODE_COUNT = hbm_pkg::NodeCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hbm_in_if.sink     in_i,
  hbm_out_if.source  out_o,
  hbm_cfg_if.sink    cfg_i
);
  import hbm_pkg::*;

`include "can_node_heartbeat_monitor_macros.svh"

  localparam int unsigned AddrW = $clog2(NODE_COUNT);

  typedef enum logic {
    S_IDLE,
    S_RMW
  } state_e;

  localparam entry_t EntryRst = '{last_heard: '0, fack: FackLimitRst, report: '0,
                                  init: InitStartRst};

  state_e            state_q;
  logic [ReqW-1:0]   req_q;
  logic [TickW-1:0]  tick_q;
  logic [AddrW-1:0]  addr_q;
  logic              hit_q;
  logic              matched_q;
  logic [NODE_COUNT-1:0] vld_q;
  logic [CountW-1:0] fack0_q, init0_q, fack1_q, init1_q;
  logic [CountW-1:0] fack0_d, init0_d, fack1_d, init1_d;

  logic              out_valid_q;
  logic              out_matched_q;
  logic [StatusW-1:0] out_status_q, out_comb_q;
  entry_t            out_entry_q;

  match_t            match;
  logic [CountW-1:0] fack_limit;
  logic              accept;
  logic              go;
  logic [AddrW-1:0]  addr_d;
  logic              hit_d;
  entry_t            rdata, cur, upd;
  status_e           comb;

  hbm_regs #(
    .NODE_COUNT(NODE_COUNT)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .frame_id_i  (in_i.frame_id),
    .match_o     (match),
    .fack_limit_o(fack_limit)
  );

  // Accept in idle; the read is issued on the same edge
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign go         = (state_q == S_RMW) && (!out_valid_q || out_o.ready);

  always_comb begin
    if (in_i.req_type == REQ_FRAME) begin
      hit_d  = match.hit;
      addr_d = match.idx[AddrW-1:0];
    end else begin
      hit_d  = in_i.node_index < NodeIdxW'(NODE_COUNT);
      addr_d = in_i.node_index[AddrW-1:0];
    end
  end

  hbm_ram #(
    .Width(EntryW),
    .Depth(NODE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (go && hit_q),
    .waddr_i(addr_q),
    .wdata_i(upd),
    .re_i   (accept),
    .raddr_i(addr_d),
    .rdata_o(rdata)
  );

  // Modify the entry
  assign cur = vld_q[addr_q] ? rdata : EntryRst;

  always_comb begin
    upd = cur;
    case (req_q)
      REQ_FRAME: begin
        upd = '{last_heard: tick_q, fack: '0, report: '0, init: '0};
      end
      REQ_FACK: begin
        if (cur.fack != CountMax) upd.fack = cur.fack + 8'd1;
      end
      REQ_REPORT: begin
        if (cur.report != CountMax) upd.report = cur.report + 8'd1;
      end
      REQ_STEP: begin
        if (cur.init != '0) upd.init = cur.init - 8'd1;
      end
      REQ_CLEAR: begin
        upd.last_heard = '0;
      end
      default: begin
      end
    endcase
  end

  // Mirrors of entries 0 and 1 for the combined status
  always_comb begin
    fack0_d = fack0_q;
    init0_d = init0_q;
    fack1_d = fack1_q;
    init1_d = init1_q;
    if (go && hit_q && addr_q == AddrW'(0)) begin
      fack0_d = upd.fack;
      init0_d = upd.init;
    end
    if (go && hit_q && addr_q == AddrW'(1)) begin
      fack1_d = upd.fack;
      init1_d = upd.init;
    end
  end

  assign comb = combine(status_of(fack1_d, init1_d, fack_limit),
                        status_of(fack0_d, init0_d, fack_limit));

  // Control state, table bookkeeping and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      req_q         <= '0;
      tick_q        <= '0;
      addr_q        <= '0;
      hit_q         <= 1'b0;
      matched_q     <= 1'b0;
      vld_q         <= '0;
      fack0_q       <= FackLimitRst;
      init0_q       <= InitStartRst;
      fack1_q       <= FackLimitRst;
      init1_q       <= InitStartRst;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_status_q  <= '0;
      out_comb_q    <= '0;
      out_entry_q   <= '0;
    end else begin
      fack0_q <= fack0_d;
      init0_q <= init0_d;
      fack1_q <= fack1_d;
      init1_q <= init1_d;
      // A taken result is dropped unless a new one replaces it on this edge
      if (out_valid_q && out_o.ready && !go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q     <= in_i.req_type;
            tick_q    <= in_i.now_tick;
            addr_q    <= addr_d;
            hit_q     <= hit_d;
            matched_q <= (in_i.req_type == REQ_FRAME) && match.hit;
            state_q   <= S_RMW;
          end
        end
        S_RMW: begin
          if (go) begin
            if (hit_q) begin
              vld_q[addr_q] <= 1'b1;
            end
            out_valid_q   <= 1'b1;
            out_matched_q <= matched_q;
            out_comb_q    <= comb;
            out_status_q  <= hit_q ? status_of(upd.fack, upd.init, fack_limit) : '0;
            out_entry_q   <= hit_q ? upd : '0;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.matched         = out_matched_q;
  assign out_o.node_status     = out_status_q;
  assign out_o.combined_status = out_comb_q;
  assign out_o.last_heard      = out_entry_q.last_heard;
  assign out_o.fack_count      = out_entry_q.fack;
  assign out_o.report_count    = out_entry_q.report;
  assign out_o.init_count      = out_entry_q.init;

  // An accepted item always moves to the write-back cycle
  `HBM_ASSERT_NXT(a_accept_rmw, accept, state_q == S_RMW)
  // A refreshed entry has its counts cleared
  `HBM_ASSERT_NOW(a_match_clear, out_valid_q && out_matched_q,
                  out_entry_q.fack == '0 && out_entry_q.init == '0)
  // Initializing status only with a running countdown
  `HBM_ASSERT_NOW(a_init_status, out_valid_q && out_status_q == ST_INIT && hit_q,
                  out_entry_q.init != '0 || !out_matched_q)

endmodule
